// ===== rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants for the linear-probe hash table
// Operation, status and flag codes, mixer constants, slot store structs.
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int LIVE_W        = 11;
   localparam int LIMIT_W       = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd75;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 7'd99;

   localparam logic [31:0] MIX_MUL_1 = 32'h21f0aaad;
   localparam logic [31:0] MIX_MUL_2 = 32'hd35a2d97;
   localparam int          MIX_SHIFT_1 = 16;
   localparam int          MIX_SHIFT_2 = 15;

   // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for y below 9801
   localparam logic [13:0] RECIP_100   = 14'd10486;
   localparam int          RECIP_SHIFT = 20;

   localparam logic [1:0] FLAG_EMPTY  = 2'b00;
   localparam logic [1:0] FLAG_IN_USE = 2'b01;
   localparam logic [1:0] FLAG_TOMB   = 2'b11;

   typedef enum logic [1:0] {
      OP_PUT         = 2'd0,
      OP_GET         = 2'd1,
      OP_GET_DEFAULT = 2'd2,
      OP_REMOVE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_OK     = 2'd0,
      RSP_ABSENT = 2'd1,
      RSP_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } state_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_MUL1,
      HS_MUL2,
      HS_QUOT,
      HS_REM,
      HS_DONE
   } hash_state_type;

   typedef struct packed {
      logic       flags_en;
      logic       key_en;
      logic       value_en;
      logic [1:0] flags;
   } slot_wr_type;

   typedef struct packed {
      logic [1:0]         flags;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_rd_type;

endpackage

// ===== rtl/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: fixed-capacity key/value store
// Put, get, get-or-insert-default and remove over a linear-probe slot array
// with tombstones and a programmable load limit.
// ----------------------------------------------------------------------------
//   Channel   Ports                                   Handshake
//   request   req_op, req_key, req_value              start & !busy
//   response  rsp_status, rsp_value_out, rsp_live_count  rsp_strobe, one cycle
//   control   csr_wr_data (load limit percent)        csr_wr_en
//
// A request runs through the mixer, plus the reciprocal quotient and remainder
// steps when SLOTS is not a power of two, and then probes slots, one memory read
// per cycle, until its response is shown on rsp_strobe. After reset, busy stays
// high while the flag memory is swept empty. The response cannot be stalled; a
// new request may be accepted in the cycle its response is shown.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
   parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [lph_pkg::KEY_W-1:0]     req_key,
   input  logic [lph_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [lph_pkg::VALUE_W-1:0]   rsp_value_out,
   output logic [lph_pkg::LIVE_W-1:0]    rsp_live_count,
   input  logic                          csr_wr_en,
   input  logic [lph_pkg::LIMIT_W-1:0]   csr_wr_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CAP_Q = SLOTS / 100;
   localparam int CAP_R = SLOTS % 100;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   lph_pkg::state_type  state_ff, state_in;
   lph_pkg::op_type     op_ff;
   logic [lph_pkg::KEY_W-1:0]   key_ff;
   logic [lph_pkg::VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            entry_ff, entry_in;
   logic [CNT_W-1:0]            tomb_ff, tomb_in;
   logic [lph_pkg::LIMIT_W-1:0] lim_ff;
   logic [CNT_W-1:0]            cap_ff, cap_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   lph_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [lph_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [lph_pkg::LIVE_W-1:0]  rsp_live_ff, rsp_live_in;

   logic                        accept;
   logic                        clear_busy;
   logic                        hash_start;
   logic                        hash_done;
   logic [IDX_W-1:0]            hash_slot;
   logic [IDX_W-1:0]            rd_addr;
   logic [IDX_W-1:0]            idx_next;
   lph_pkg::slot_rd_type        rd_data;
   lph_pkg::slot_wr_type        wr_ctl;
   logic                        live;
   logic                        insert_ok;

   logic [lph_pkg::LIMIT_W-1:0]   lim_c;
   logic [CNT_W+lph_pkg::LIMIT_W-1:0] cap_qprod;
   logic [13:0]                   cap_rprod;
   logic [27:0]                   cap_rscaled;

   assign busy           = (state_ff != lph_pkg::ST_IDLE) || clear_busy;
   assign accept         = start && !busy;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_live_count = rsp_live_ff;

   assign idx_next  = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign live      = rd_data.flags[0] && !rd_data.flags[1];
   assign insert_ok = ((CNT_W+1)'(entry_ff) + (CNT_W+1)'(tomb_ff) + (CNT_W+1)'(1))
                      <= (CNT_W+1)'(cap_ff);

   assign lim_c       = (lim_ff > lph_pkg::LIMIT_MAX) ? lph_pkg::LIMIT_MAX : lim_ff;
   assign cap_qprod   = (CNT_W+lph_pkg::LIMIT_W)'(CAP_Q)
                        * (CNT_W+lph_pkg::LIMIT_W)'(lim_c);
   assign cap_rprod   = 14'(CAP_R) * 14'(lim_c);
   assign cap_rscaled = 28'(cap_rprod) * 28'(lph_pkg::RECIP_100);
   assign cap_in      = CNT_W'(cap_qprod) + CNT_W'(cap_rscaled >> lph_pkg::RECIP_SHIFT);

   lph_hash_unit #(
      .SLOTS(SLOTS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   lph_slot_store #(
      .SLOTS(SLOTS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_ctl     (wr_ctl),
      .wr_addr    (idx_ff),
      .wr_key     (key_ff),
      .wr_value   (value_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lph_pkg::ST_IDLE;
         entry_ff      <= '0;
         tomb_ff       <= '0;
         lim_ff        <= lph_pkg::LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entry_ff      <= entry_in;
         tomb_ff       <= tomb_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            lim_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= lph_pkg::op_type'(req_op);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      idx_ff        <= idx_in;
      cap_ff        <= cap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_live_ff   <= rsp_live_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      entry_in      = entry_ff;
      tomb_in       = tomb_ff;
      rd_addr       = idx_ff;
      hash_start    = 1'b0;
      wr_ctl        = '0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = lph_pkg::RSP_OK;
      rsp_value_in  = '0;
      case (state_ff)
         lph_pkg::ST_IDLE: begin
            if (accept) begin
               hash_start = 1'b1;
               state_in   = lph_pkg::ST_HASH;
            end
         end
         lph_pkg::ST_HASH: begin
            if (hash_done) begin
               rd_addr  = hash_slot;
               idx_in   = hash_slot;
               state_in = lph_pkg::ST_PROBE;
            end
         end
         lph_pkg::ST_PROBE: begin
            if (rd_data.flags[0] && (rd_data.key != key_ff)) begin
               rd_addr = idx_next;
               idx_in  = idx_next;
            end else begin
               state_in      = lph_pkg::ST_IDLE;
               rsp_strobe_in = 1'b1;
               case (op_ff)
                  lph_pkg::OP_GET: begin
                     if (live) begin
                        rsp_value_in = rd_data.value;
                     end else begin
                        rsp_status_in = lph_pkg::RSP_ABSENT;
                     end
                  end
                  lph_pkg::OP_REMOVE: begin
                     if (live) begin
                        wr_ctl.flags_en = 1'b1;
                        wr_ctl.flags    = lph_pkg::FLAG_TOMB;
                        entry_in        = entry_ff - CNT_W'(1);
                        tomb_in         = tomb_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = lph_pkg::RSP_ABSENT;
                     end
                  end
                  default: begin
                     if (live) begin
                        if (op_ff == lph_pkg::OP_PUT) begin
                           wr_ctl.value_en = 1'b1;
                           rsp_value_in    = value_ff;
                        end else begin
                           rsp_value_in = rd_data.value;
                        end
                     end else if (rd_data.flags[0]) begin
                        wr_ctl.flags_en = 1'b1;
                        wr_ctl.value_en = 1'b1;
                        wr_ctl.flags    = lph_pkg::FLAG_IN_USE;
                        entry_in        = entry_ff + CNT_W'(1);
                        tomb_in         = tomb_ff - CNT_W'(1);
                        rsp_value_in    = value_ff;
                     end else if (insert_ok) begin
                        wr_ctl.flags_en = 1'b1;
                        wr_ctl.key_en   = 1'b1;
                        wr_ctl.value_en = 1'b1;
                        wr_ctl.flags    = lph_pkg::FLAG_IN_USE;
                        entry_in        = entry_ff + CNT_W'(1);
                        rsp_value_in    = value_ff;
                     end else begin
                        rsp_status_in = lph_pkg::RSP_FULL;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = lph_pkg::ST_IDLE;
         end
      endcase
      rsp_live_in = lph_pkg::LIVE_W'(entry_in);
   end

`ifndef SYNTHESIS
   a_empty_slot_kept: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W+1)'(entry_ff) + (CNT_W+1)'(tomb_ff)) < (CNT_W+1)'(SLOTS))
      else $error("live plus tombstoned entries reached the slot count");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_strobe)
      else $error("response strobe right after request acceptance");

   a_rsp_from_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == lph_pkg::ST_PROBE) && !busy)
      else $error("response strobe without a finished probe");

   a_full_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == lph_pkg::RSP_FULL)) |->
         ((op_ff == lph_pkg::OP_PUT) || (op_ff == lph_pkg::OP_GET_DEFAULT))
         && (rsp_value_out == '0) && $stable(entry_ff))
      else $error("full status on a non-inserting request");
`endif

endmodule

// ===== rtl/lph_hash_unit.sv =====
// ----------------------------------------------------------------------------
// lph_hash_unit: key mixer and home slot reduction
// One shared 32x32 multiplier runs both mixer rounds; a non power of two
// slot count is reduced by a reciprocal multiply and a back multiply on the
// same multiplier, then one compare and subtract.
// ----------------------------------------------------------------------------
module lph_hash_unit #(
   parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lph_pkg::KEY_W-1:0] key,
   output logic                      done,
   output logic [$clog2(SLOTS)-1:0]  slot
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam bit IS_POW2 = ((1 << IDX_W) == SLOTS);
   localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W+1)'(SLOTS);
   localparam logic [31:0] SLOTS_32 = 32'(SLOTS);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

   lph_pkg::hash_state_type state_ff, state_in;
   logic [31:0]      h_ff, h_in;
   logic [31:0]      quot_rem_ff, quot_rem_in;

   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      mul_full;
   logic [31:0]      fin;
   logic [IDX_W:0]   rem_raw;
   logic [IDX_W-1:0] rem_fix;

   assign mul_full = 64'(mul_a) * 64'(mul_b);
   assign fin      = h_ff ^ (h_ff >> lph_pkg::MIX_SHIFT_2);
   assign rem_raw  = quot_rem_ff[IDX_W:0];
   assign rem_fix  = (rem_raw >= SLOTS_EXT) ? IDX_W'(rem_raw - SLOTS_EXT)
                                            : rem_raw[IDX_W-1:0];
   assign slot     = IS_POW2 ? fin[IDX_W-1:0] : rem_fix;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lph_pkg::HS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      quot_rem_ff <= quot_rem_in;
   end

   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      quot_rem_in = quot_rem_ff;
      done        = 1'b0;
      mul_a       = h_ff;
      mul_b       = lph_pkg::MIX_MUL_1;
      case (state_ff)
         lph_pkg::HS_IDLE: begin
            if (start) begin
               h_in     = key ^ (key >> lph_pkg::MIX_SHIFT_1);
               state_in = lph_pkg::HS_MUL1;
            end
         end
         lph_pkg::HS_MUL1: begin
            h_in     = mul_full[31:0];
            state_in = lph_pkg::HS_MUL2;
         end
         lph_pkg::HS_MUL2: begin
            mul_a    = h_ff ^ (h_ff >> lph_pkg::MIX_SHIFT_2);
            mul_b    = lph_pkg::MIX_MUL_2;
            h_in     = mul_full[31:0];
            state_in = IS_POW2 ? lph_pkg::HS_DONE : lph_pkg::HS_QUOT;
         end
         lph_pkg::HS_QUOT: begin
            mul_a       = fin;
            mul_b       = RECIP;
            quot_rem_in = mul_full[63:32];
            state_in    = lph_pkg::HS_REM;
         end
         lph_pkg::HS_REM: begin
            mul_a       = quot_rem_ff;
            mul_b       = SLOTS_32;
            quot_rem_in = fin - mul_full[31:0];
            state_in    = lph_pkg::HS_DONE;
         end
         lph_pkg::HS_DONE: begin
            done     = 1'b1;
            state_in = lph_pkg::HS_IDLE;
         end
         default: begin
            state_in = lph_pkg::HS_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/lph_slot_store.sv =====
// ----------------------------------------------------------------------------
// lph_slot_store: key, value and flag memories of the slot array
// One registered read port, one write port; flags swept empty after reset.
// ----------------------------------------------------------------------------
module lph_slot_store #(
   parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        clear_busy,
   input  logic [$clog2(SLOTS)-1:0]    rd_addr,
   output lph_pkg::slot_rd_type        rd_data,
   input  lph_pkg::slot_wr_type        wr_ctl,
   input  logic [$clog2(SLOTS)-1:0]    wr_addr,
   input  logic [lph_pkg::KEY_W-1:0]   wr_key,
   input  logic [lph_pkg::VALUE_W-1:0] wr_value
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [1:0]                  flag_mem  [SLOTS];
   logic [lph_pkg::KEY_W-1:0]   key_mem   [SLOTS];
   logic [lph_pkg::VALUE_W-1:0] value_mem [SLOTS];

   logic                        clr_busy_ff;
   logic [IDX_W-1:0]            clr_idx_ff;
   logic [1:0]                  rd_flags_ff;
   logic [lph_pkg::KEY_W-1:0]   rd_key_ff;
   logic [lph_pkg::VALUE_W-1:0] rd_value_ff;

   logic             flag_we;
   logic [IDX_W-1:0] flag_addr;
   logic [1:0]       flag_data;

   assign clear_busy = clr_busy_ff;
   assign flag_we    = clr_busy_ff || wr_ctl.flags_en;
   assign flag_addr  = clr_busy_ff ? clr_idx_ff : wr_addr;
   assign flag_data  = clr_busy_ff ? lph_pkg::FLAG_EMPTY : wr_ctl.flags;
   assign rd_data    = '{flags: rd_flags_ff, key: rd_key_ff, value: rd_value_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_addr] <= flag_data;
      end
      rd_flags_ff <= flag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      rd_value_ff <= value_mem[rd_addr];
   end

endmodule
